[src/vca_pkg.sv]
// ----------------------------------------------------------------------------
// vca_pkg: shared types for the voice channel allocator
// Request/response payloads, the scan token passed along the channel cells,
// and the commit bundle broadcast to the cells at the end of a scan.
// ----------------------------------------------------------------------------
package vca_pkg;

   localparam int CHANNELS_DEF = 12;
   localparam int TRACKS_DEF   = 16;

   // sized for the largest supported channel count (32)
   localparam int PICK_W  = 5;
   localparam int LIMIT_W = 6;

   typedef enum logic [2:0] {
      FUNC_NOTE_ON      = 3'd0,
      FUNC_NOTE_OFF     = 3'd1,
      FUNC_ALL_OFF      = 3'd2,
      FUNC_SOUND_OFF    = 3'd3,
      FUNC_RELEASE_DONE = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      HOW_IDLE      = 2'd0,
      HOW_RELEASING = 2'd1,
      HOW_PLAYING   = 2'd2
   } how_type;

   typedef struct packed {
      logic [2:0] func;
      logic [3:0] track;
      logic [6:0] key;
      logic [7:0] priority_req;
      logic [3:0] channel;
   } req_type;

   typedef struct packed {
      logic       granted;
      logic [3:0] slot;
      logic [1:0] how_taken;
      logic [3:0] marked_count;
   } rsp_type;

   // scan token, one hop per cycle
   typedef struct packed {
      logic               valid;
      logic               act;      // request has an effect at all
      func_type           func;
      logic [3:0]         trk;
      logic [6:0]         key;
      logic [7:0]         pri;
      logic [3:0]         ch;
      logic [LIMIT_W-1:0] limit;    // channels a note on may scan
      logic               done;     // idle channel already found
      logic               found;    // a channel has been picked
      logic               idle;
      logic               rel;      // a releasing channel was seen
      logic [7:0]         best_pri;
      logic [3:0]         best_trk;
      logic [PICK_W-1:0]  pick;
      logic [3:0]         cnt;
   } token_type;

   typedef struct packed {
      logic              we;
      logic [PICK_W-1:0] pick;
      logic [7:0]        pri;
      logic [3:0]        trk;
      logic [6:0]        key;
   } commit_type;

   function automatic logic [3:0] sat_inc(input logic [3:0] v);
      sat_inc = (v == 4'hF) ? v : v + 4'd1;
   endfunction

endpackage

[src/vca_cell.sv]
// ----------------------------------------------------------------------------
// vca_cell: one channel of the allocator
// Holds the channel's state, updates the passing scan token and its own
// state, and takes the note-on commit addressed to it.
// ----------------------------------------------------------------------------
module vca_cell #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  vca_pkg::token_type  tok_i,
   input  vca_pkg::commit_type commit_i,
   output vca_pkg::token_type  tok_o
);

   vca_pkg::token_type tok_ff, tok_in;
   logic       active_ff, active_in;
   logic       releasing_ff, releasing_in;
   logic [7:0] pri_ff, pri_in;
   logic [3:0] trk_ff, trk_in;
   logic [6:0] key_ff, key_in;

   // token update and channel state update
   always_comb begin
      logic better;
      logic take;
      better       = 1'b0;
      take         = 1'b0;
      tok_in       = tok_i;
      active_in    = active_ff;
      releasing_in = releasing_ff;
      pri_in       = pri_ff;
      trk_in       = trk_ff;
      key_in       = key_ff;
      if (tok_i.valid && tok_i.act) begin
         case (tok_i.func)
            vca_pkg::FUNC_NOTE_ON: begin
               if (!tok_i.done && int'(tok_i.limit) > IDX) begin
                  if (!active_ff) begin
                     tok_in.done  = 1'b1;
                     tok_in.found = 1'b1;
                     tok_in.idle  = 1'b1;
                     tok_in.pick  = vca_pkg::PICK_W'(IDX);
                  end else begin
                     better = (pri_ff < tok_i.best_pri) ||
                              (pri_ff == tok_i.best_pri && trk_ff >= tok_i.best_trk);
                     take   = releasing_ff ? (!tok_i.rel || better) : (!tok_i.rel && better);
                     if (releasing_ff) begin
                        tok_in.rel = 1'b1;
                     end
                     if (take) begin
                        tok_in.found    = 1'b1;
                        tok_in.best_pri = pri_ff;
                        tok_in.best_trk = trk_ff;
                        tok_in.pick     = vca_pkg::PICK_W'(IDX);
                     end
                  end
               end
            end
            vca_pkg::FUNC_NOTE_OFF: begin
               if (active_ff && !releasing_ff && trk_ff == tok_i.trk && key_ff == tok_i.key) begin
                  releasing_in = 1'b1;
                  tok_in.cnt   = vca_pkg::sat_inc(tok_i.cnt);
               end
            end
            vca_pkg::FUNC_ALL_OFF: begin
               if (active_ff && !releasing_ff && trk_ff == tok_i.trk) begin
                  releasing_in = 1'b1;
                  tok_in.cnt   = vca_pkg::sat_inc(tok_i.cnt);
               end
            end
            vca_pkg::FUNC_SOUND_OFF: begin
               if (active_ff) begin
                  tok_in.cnt = vca_pkg::sat_inc(tok_i.cnt);
               end
               active_in    = 1'b0;
               releasing_in = 1'b0;
            end
            vca_pkg::FUNC_RELEASE_DONE: begin
               if (int'(tok_i.ch) == IDX && active_ff && releasing_ff) begin
                  active_in    = 1'b0;
                  releasing_in = 1'b0;
                  tok_in.cnt   = vca_pkg::sat_inc(tok_i.cnt);
               end
            end
            default: begin
               tok_in = tok_i;
            end
         endcase
      end
      // note-on write-back at the end of the scan
      if (commit_i.we && int'(commit_i.pick) == IDX) begin
         active_in    = 1'b1;
         releasing_in = 1'b0;
         pri_in       = commit_i.pri;
         trk_in       = commit_i.trk;
         key_in       = commit_i.key;
      end
   end

   // token and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff       <= '0;
         active_ff    <= 1'b0;
         releasing_ff <= 1'b0;
      end else begin
         tok_ff       <= tok_in;
         active_ff    <= active_in;
         releasing_ff <= releasing_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pri_ff <= pri_in;
      trk_ff <= trk_in;
      key_ff <= key_in;
   end

   assign tok_o = tok_ff;

endmodule

[src/voice_channel_allocator.sv]
// ----------------------------------------------------------------------------
// voice_channel_allocator: voice channel allocation with priority stealing
//
//   channel   ports                          handshake
//   request   start, busy, req_item          taken when start & !busy
//   response  rsp_valid, rsp_item            one-cycle strobe, never held off
//   csr       csr_we, csr_wdata              written when csr_we
//
// A request sends a token down the chain of CHANNELS cells, one cell per
// cycle; the response strobe is registered from the last cell's token and busy
// drops at the same edge, so a new request is taken only once the previous token has left the chain.
// Reset clears all channels to idle and channels_in_use to 0.
// The response side cannot stall; only busy holds off new requests.
// ----------------------------------------------------------------------------
module voice_channel_allocator #(
   parameter int CHANNELS = vca_pkg::CHANNELS_DEF,
   parameter int TRACKS   = vca_pkg::TRACKS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vca_pkg::req_type req_item,
   output logic             rsp_valid,
   output vca_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [3:0]       csr_wdata
);

   logic               busy_ff, busy_in;
   logic [3:0]         ciu_ff, ciu_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vca_pkg::rsp_type   rsp_item_ff, rsp_item_in;
   vca_pkg::token_type launch;
   vca_pkg::token_type chain [0:CHANNELS];
   vca_pkg::token_type last;
   vca_pkg::commit_type commit;
   logic               accept;
   logic               func_ok;

   assign accept = start && !busy_ff;

   // build the token for a new request
   always_comb begin
      func_ok = (req_item.func <= 3'(vca_pkg::FUNC_RELEASE_DONE));
      if (req_item.func <= 3'(vca_pkg::FUNC_ALL_OFF) && int'(req_item.track) >= TRACKS) begin
         func_ok = 1'b0;
      end
      launch          = '0;
      launch.valid    = accept;
      launch.act      = func_ok;
      launch.func     = vca_pkg::func_type'(req_item.func);
      launch.trk      = req_item.track;
      launch.key      = req_item.key;
      launch.pri      = req_item.priority_req;
      launch.ch       = req_item.channel;
      launch.best_pri = req_item.priority_req;
      launch.best_trk = req_item.track;
      if (ciu_ff == 4'd0 || int'(ciu_ff) > CHANNELS) begin
         launch.limit = vca_pkg::LIMIT_W'(CHANNELS);
      end else begin
         launch.limit = vca_pkg::LIMIT_W'(ciu_ff);
      end
   end

   assign chain[0] = launch;

   // channel cells
   for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
      vca_cell #(
         .IDX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_i    (chain[g]),
         .commit_i (commit),
         .tok_o    (chain[g+1])
      );
   end

   assign last = chain[CHANNELS];

   // note-on write-back and response
   always_comb begin
      logic is_on;
      is_on          = last.valid && last.act && last.func == vca_pkg::FUNC_NOTE_ON;
      commit.we      = is_on && last.found;
      commit.pick    = last.pick;
      commit.pri     = last.pri;
      commit.trk     = last.trk;
      commit.key     = last.key;
      rsp_valid_in   = last.valid;
      rsp_item_in    = '0;
      if (commit.we) begin
         rsp_item_in.granted = 1'b1;
         rsp_item_in.slot    = last.pick[3:0];
         if (last.idle) begin
            rsp_item_in.how_taken = vca_pkg::HOW_IDLE;
         end else if (last.rel) begin
            rsp_item_in.how_taken = vca_pkg::HOW_RELEASING;
         end else begin
            rsp_item_in.how_taken = vca_pkg::HOW_PLAYING;
         end
      end
      if (last.act) begin
         rsp_item_in.marked_count = last.cnt;
      end
      busy_in = accept ? 1'b1 : (last.valid ? 1'b0 : busy_ff);
      ciu_in  = csr_we ? csr_wdata : ciu_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         ciu_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         ciu_ff       <= ciu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[src/vca_checker.sv]
// ----------------------------------------------------------------------------
// vca_checker: port-level checks for the voice channel allocator
// Watches the request and response ports; attached by bind.
// ----------------------------------------------------------------------------
module vca_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input vca_pkg::rsp_type rsp_item
);

   // one response per request, so strobes never run back to back
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // an accepted request makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // a refused note on carries no slot or method
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.granted) |-> (rsp_item.slot == 4'd0 && rsp_item.how_taken == 2'd0))
      else $error("refused response with nonzero slot or method");

   // a granted note on never marks channels
   a_grant_no_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.granted) |-> (rsp_item.marked_count == 4'd0))
      else $error("granted response with nonzero marked count");

endmodule

bind voice_channel_allocator vca_checker u_vca_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

[verif/tb_voice_channel_allocator.sv]
// ----------------------------------------------------------------------------
// tb_voice_channel_allocator: self-checking bench for the voice allocator
// Note events go in through the start/busy handshake; a local copy of the
// channel table predicts every response. Responses are compared field by
// field in order. The scan limit is changed only between phases, once all
// responses are back.
// ----------------------------------------------------------------------------
module tb_voice_channel_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS    = 12;
   localparam int TRACKS      = 16;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASE_ITEMS = 50;

   // func codes the block does not decode
   localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;

   typedef struct {
      bit               is_csr;
      logic [3:0]       csr_val;
      vca_pkg::req_type req;
   } note_op_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   vca_pkg::req_type req_item  = '0;
   logic             rsp_valid;
   vca_pkg::rsp_type rsp_item;
   logic             csr_we    = 1'b0;
   logic [3:0]       csr_wdata = 4'd0;

   note_op_type      note_op_q[$];
   vca_pkg::rsp_type alloc_result_q[$];
   bit               failed;

   // local channel table
   logic [CHANNELS-1:0] voice_on;
   logic [CHANNELS-1:0] voice_releasing;
   logic [7:0]          voice_pri [CHANNELS];
   logic [3:0]          voice_trk [CHANNELS];
   logic [6:0]          voice_key [CHANNELS];
   logic [3:0]          scan_limit;

   int idle_gap;
   int calm_left;
   int stall_cycles;
   bit took;
   bit raise_csr;

   voice_channel_allocator #(
      .CHANNELS(CHANNELS),
      .TRACKS  (TRACKS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected response of one request; updates the channel table
   function automatic vca_pkg::rsp_type predict_voice(vca_pkg::req_type r);
      vca_pkg::rsp_type res;
      int      n;
      int      idle_at;
      int      pick;
      bit      rel;
      bit      take;
      logic [7:0] best_pri;
      logic [3:0] best_trk;
      int      cnt;
      res = '0;
      cnt = 0;
      if (r.func <= vca_pkg::FUNC_ALL_OFF && r.track >= TRACKS) return res;
      case (r.func)
         vca_pkg::FUNC_NOTE_ON: begin
            n = scan_limit;
            if (n == 0 || n > CHANNELS) n = CHANNELS;
            idle_at  = -1;
            pick     = -1;
            rel      = 1'b0;
            best_pri = r.priority_req;
            best_trk = r.track;
            for (int i = 0; i < n && idle_at < 0; i++) begin
               if (!voice_on[i]) begin
                  idle_at = i;
               end else begin
                  // a releasing channel always beats a playing one
                  if (voice_releasing[i]) begin
                     take = !rel || voice_pri[i] < best_pri ||
                            (voice_pri[i] == best_pri && voice_trk[i] >= best_trk);
                     rel  = 1'b1;
                  end else begin
                     take = !rel && (voice_pri[i] < best_pri ||
                            (voice_pri[i] == best_pri && voice_trk[i] >= best_trk));
                  end
                  if (take) begin
                     best_pri = voice_pri[i];
                     best_trk = voice_trk[i];
                     pick     = i;
                  end
               end
            end
            if (idle_at >= 0) begin
               pick = idle_at;
               res.how_taken = vca_pkg::HOW_IDLE;
            end else begin
               res.how_taken = rel ? vca_pkg::HOW_RELEASING : vca_pkg::HOW_PLAYING;
            end
            if (pick >= 0) begin
               voice_on[pick]        = 1'b1;
               voice_releasing[pick] = 1'b0;
               voice_pri[pick]       = r.priority_req;
               voice_trk[pick]       = r.track;
               voice_key[pick]       = r.key;
               res.granted           = 1'b1;
               res.slot              = 4'(pick);
            end else begin
               res.how_taken = vca_pkg::HOW_IDLE;
            end
         end
         vca_pkg::FUNC_NOTE_OFF: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (voice_on[i] && !voice_releasing[i] &&
                   voice_trk[i] == r.track && voice_key[i] == r.key) begin
                  voice_releasing[i] = 1'b1;
                  cnt++;
               end
            end
         end
         vca_pkg::FUNC_ALL_OFF: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (voice_on[i] && !voice_releasing[i] && voice_trk[i] == r.track) begin
                  voice_releasing[i] = 1'b1;
                  cnt++;
               end
            end
         end
         vca_pkg::FUNC_SOUND_OFF: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (voice_on[i]) cnt++;
            end
            voice_on        = '0;
            voice_releasing = '0;
         end
         vca_pkg::FUNC_RELEASE_DONE: begin
            if (r.channel < CHANNELS && voice_on[r.channel] &&
                voice_releasing[r.channel]) begin
               voice_on[r.channel]        = 1'b0;
               voice_releasing[r.channel] = 1'b0;
               cnt = 1;
            end
         end
         default: ;
      endcase
      res.marked_count = (cnt > 15) ? 4'd15 : 4'(cnt);
      return res;
   endfunction

   // gap after a request: mostly short, a few long, with calm stretches
   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 5) calm_left = $urandom_range(30, 10);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(4, 1);
      if (r < 95) return $urandom_range(16, 5);
      return $urandom_range(60, 17);
   endfunction

   task automatic add_req(logic [2:0] f, logic [3:0] trk, logic [6:0] k,
                          logic [7:0] pri, logic [3:0] ch);
      note_op_type op;
      op.is_csr           = 1'b0;
      op.csr_val          = '0;
      op.req.func         = f;
      op.req.track        = trk;
      op.req.key          = k;
      op.req.priority_req = pri;
      op.req.channel      = ch;
      note_op_q.push_back(op);
   endtask

   task automatic add_csr(logic [3:0] val);
      note_op_type op;
      op.is_csr  = 1'b1;
      op.csr_val = val;
      op.req     = '0;
      note_op_q.push_back(op);
   endtask

   // small track/key/priority pools so note offs match and ties occur
   task automatic add_random_req();
      logic [2:0] f;
      int         sel;
      sel = $urandom_range(99);
      if (sel < 45)      f = vca_pkg::FUNC_NOTE_ON;
      else if (sel < 65) f = vca_pkg::FUNC_NOTE_OFF;
      else if (sel < 73) f = vca_pkg::FUNC_ALL_OFF;
      else if (sel < 76) f = vca_pkg::FUNC_SOUND_OFF;
      else if (sel < 96) f = vca_pkg::FUNC_RELEASE_DONE;
      else               f = 3'($urandom_range(FUNC_LAST_UNUSED, FUNC_FIRST_UNUSED));
      add_req(f,
              4'($urandom_range(99) < 70 ? $urandom_range(3) : $urandom_range(15)),
              7'($urandom_range(99) < 70 ? $urandom_range(7) : $urandom_range(127)),
              8'($urandom_range(99) < 60 ? $urandom_range(3) : $urandom_range(255)),
              4'($urandom_range(99) < 85 ? $urandom_range(11) : $urandom_range(15)));
   endtask

   // driver: requests and csr writes from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         start           <= 1'b0;
         csr_we          <= 1'b0;
         voice_on        = '0;
         voice_releasing = '0;
         scan_limit      = 4'd0;
         idle_gap        = 0;
      end else begin
         took      = start && !busy;
         raise_csr = 1'b0;
         if (took) alloc_result_q.push_back(predict_voice(req_item));
         if (csr_we) scan_limit = csr_wdata;
         if (start && !took) begin
            // request held off by busy
         end else if (idle_gap > 0) begin
            start <= 1'b0;
            idle_gap--;
         end else if (note_op_q.size() > 0 && note_op_q[0].is_csr) begin
            start <= 1'b0;
            // csr writes only with the block idle and nothing outstanding
            if (!took && !busy && !csr_we && alloc_result_q.size() == 0) begin
               raise_csr = 1'b1;
               csr_wdata <= note_op_q[0].csr_val;
               void'(note_op_q.pop_front());
            end
         end else if (note_op_q.size() > 0) begin
            start    <= 1'b1;
            req_item <= note_op_q[0].req;
            void'(note_op_q.pop_front());
            idle_gap = pick_gap();
         end else begin
            start <= 1'b0;
         end
         csr_we <= raise_csr;
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         failed = 1'b1;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (alloc_result_q.size() == 0) begin
            failed = 1'b1;
            $display("%0t: response with none pending, expected nothing actual %p",
                     $time, rsp_item);
         end else begin
            check_field("granted",      alloc_result_q[0].granted,      rsp_item.granted);
            check_field("slot",         alloc_result_q[0].slot,         rsp_item.slot);
            check_field("how_taken",    alloc_result_q[0].how_taken,    rsp_item.how_taken);
            check_field("marked_count", alloc_result_q[0].marked_count, rsp_item.marked_count);
            void'(alloc_result_q.pop_front());
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      logic [3:0] phase_limit [8];
      phase_limit = '{4'd12, 4'd1, 4'd0, 4'd15, 4'd5, 4'd0, 4'd3, 4'd12};
      phase_limit[5] = 4'($urandom_range(15));

      // directed: three channels scanned
      add_csr(4'd3);
      add_req(vca_pkg::FUNC_NOTE_ON,      4'd5,  7'd60,  8'd100, 4'd0);
      add_req(vca_pkg::FUNC_NOTE_ON,      4'd15, 7'd127, 8'd255, 4'd0);
      add_req(vca_pkg::FUNC_NOTE_ON,      4'd0,  7'd0,   8'd0,   4'd0);
      add_req(vca_pkg::FUNC_NOTE_ON,      4'd3,  7'd1,   8'd0,   4'd0);  // refused
      add_req(vca_pkg::FUNC_NOTE_ON,      4'd0,  7'd2,   8'd0,   4'd0);  // steals playing, tie
      add_req(vca_pkg::FUNC_NOTE_OFF,     4'd5,  7'd60,  8'd0,   4'd0);
      add_req(vca_pkg::FUNC_NOTE_ON,      4'd7,  7'd9,   8'd200, 4'd0);  // steals releasing
      add_req(vca_pkg::FUNC_ALL_OFF,      4'd15, 7'd0,   8'd0,   4'd0);
      add_req(vca_pkg::FUNC_ALL_OFF,      4'd0,  7'd0,   8'd0,   4'd0);
      add_req(vca_pkg::FUNC_NOTE_ON,      4'd9,  7'd5,   8'd255, 4'd0);  // lowest releasing wins
      add_req(vca_pkg::FUNC_RELEASE_DONE, 4'd0,  7'd0,   8'd0,   4'd1);
      add_req(vca_pkg::FUNC_RELEASE_DONE, 4'd0,  7'd0,   8'd0,   4'd1);  // already idle
      add_req(vca_pkg::FUNC_RELEASE_DONE, 4'd0,  7'd0,   8'd0,   4'd15); // out of range
      add_req(vca_pkg::FUNC_RELEASE_DONE, 4'd0,  7'd0,   8'd0,   4'd11);
      add_req(vca_pkg::FUNC_RELEASE_DONE, 4'd0,  7'd0,   8'd0,   4'd0);  // still playing
      for (int f = FUNC_FIRST_UNUSED; f <= FUNC_LAST_UNUSED; f++) begin
         add_req(3'(f), 4'd15, 7'd127, 8'd255, 4'd15);
      end
      add_req(vca_pkg::FUNC_SOUND_OFF,    4'd0,  7'd0,   8'd0,   4'd0);

      // random phases, channel table carried across scan limit changes
      foreach (phase_limit[p]) begin
         add_csr(phase_limit[p]);
         repeat (PHASE_ITEMS) add_random_req();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (note_op_q.size() != 0 || alloc_result_q.size() != 0 || start || csr_we)
         @(negedge clock);
      repeat (CHANNELS + 8) @(posedge clock);
      if (!failed) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
